FILE: rtl/mtww_pkg.sv
package mtww_pkg;

    // Defaults for the top-level parameters
    localparam int TRACKS_DEF      = 4;
    localparam int TRACK_DEPTH_DEF = 4096;
    localparam int MAX_WINDOW_DEF  = 64;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int TRK_W   = 2;
    localparam int POS_W   = 12;
    localparam int VAL_W   = 16;
    localparam int WLEN_W  = 7;
    localparam int EN_W    = 4;
    localparam int WGT_W   = 26;
    localparam int LEN_W   = 13;
    // offset + delta + window fits here for any window up to 256
    localparam int SPOS_W  = 14;
    localparam int ACC_W   = 28;

    // Port widths
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 7;

    // Command codes on the input
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SLIDE = 2'd2;

    // Operation kinds after classification
    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;
    localparam logic [1:0] OP_SLIDE = 2'd3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LEN   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TRACK_ENABLE = 1'd1;

    // Q4.12 one and the weight saturation limits
    localparam logic signed [ACC_W-1:0] ACC_ONE  = 28'sd4096;
    localparam logic signed [ACC_W-1:0] ACC_WMAX = 28'sd33554431;
    localparam logic signed [ACC_W-1:0] ACC_WMIN = -28'sd33554432;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TRK_W-1:0]  trk;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
        logic              last;
        logic [SPOS_W-1:0] base;
    } op_t;

    typedef struct packed {
        logic [WLEN_W-1:0] window_len;
        logic [EN_W-1:0]   track_enable;
    } cfg_t;

endpackage

FILE: rtl/mtww_front.sv
module mtww_front #(
    parameter int TRACKS      = mtww_pkg::TRACKS_DEF,
    parameter int TRACK_DEPTH = mtww_pkg::TRACK_DEPTH_DEF
) (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mtww_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [mtww_pkg::CMD_W-1:0]     s_tuser,
    input  logic                           s_tlast,
    input  logic                           q_full,
    output logic                           q_push,
    output mtww_pkg::op_t                  q_op
);

    localparam int NT = (TRACKS < 4) ? TRACKS : 4;

    logic [mtww_pkg::TRK_W-1:0] trk;
    logic [mtww_pkg::POS_W-1:0] pos;
    logic [mtww_pkg::VAL_W-1:0] value;
    logic [mtww_pkg::POS_W-1:0] offset;
    logic [mtww_pkg::POS_W-1:0] delta;
    logic                       load_ok;

    // Unpack the item
    assign trk    = s_tdata[1:0];
    assign pos    = s_tdata[13:2];
    assign value  = s_tdata[29:14];
    assign offset = s_tdata[41:30];
    assign delta  = s_tdata[53:42];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Loads outside the stored tracks or positions are dropped
    assign load_ok = (32'(trk) < NT) && (32'(pos) < TRACK_DEPTH);

    // Classify the item and precompute the window base
    always_comb begin
        q_op.trk   = trk;
        q_op.pos   = pos;
        q_op.value = value;
        q_op.last  = s_tlast;
        q_op.base  = mtww_pkg::SPOS_W'(offset);
        q_op.kind  = mtww_pkg::OP_NOP;
        unique case (s_tuser)
            mtww_pkg::CMD_LOAD: begin
                q_op.kind = load_ok ? mtww_pkg::OP_LOAD : mtww_pkg::OP_NOP;
            end
            mtww_pkg::CMD_INIT: begin
                q_op.kind = mtww_pkg::OP_INIT;
            end
            mtww_pkg::CMD_SLIDE: begin
                q_op.kind = mtww_pkg::OP_SLIDE;
                q_op.base = mtww_pkg::SPOS_W'(offset) + mtww_pkg::SPOS_W'(delta);
            end
            default: begin
                q_op.kind = mtww_pkg::OP_NOP;
            end
        endcase
    end

endmodule

FILE: rtl/mtww_queue.sv
module mtww_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mtww_pkg::op_t din,
    output logic          full,
    input  logic          pop,
    output mtww_pkg::op_t dout,
    output logic          empty
);

    mtww_pkg::op_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Item storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: rtl/mtww_back.sv
module mtww_back #(
    parameter int TRACKS      = mtww_pkg::TRACKS_DEF,
    parameter int TRACK_DEPTH = mtww_pkg::TRACK_DEPTH_DEF,
    parameter int MAX_WINDOW  = mtww_pkg::MAX_WINDOW_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mtww_pkg::cfg_t             cfg,
    input  logic                       q_valid,
    input  mtww_pkg::op_t              q_op,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mtww_pkg::WGT_W-1:0] m_weight
);

    localparam int NT = (TRACKS < 4) ? TRACKS : 4;
    localparam int TW = (NT > 1) ? $clog2(NT) : 1;
    localparam int PW = $clog2(TRACK_DEPTH);
    localparam int AW = TW + PW;
    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int CW = KW + 1;
    localparam int SW = mtww_pkg::SPOS_W;
    localparam int AC = mtww_pkg::ACC_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                        state_reg;
    logic [1:0]                        state_next;
    logic [1:0]                        kind_reg;
    logic [SW-1:0]                     base_reg;
    logic [TW-1:0]                     trk_reg;
    logic [TW-1:0]                     trk_next;
    logic [CW-1:0]                     j_reg;
    logic [CW-1:0]                     j_next;
    logic [mtww_pkg::LEN_W-1:0]        len_reg [NT];
    logic signed [mtww_pkg::WGT_W-1:0] running_reg;
    logic signed [AC-1:0]              acc_reg;
    logic                              m_valid_reg;
    logic [mtww_pkg::WGT_W-1:0]        m_weight_reg;

    logic [mtww_pkg::VAL_W-1:0]        mem [0:(1 << AW)-1];
    logic [mtww_pkg::VAL_W-1:0]        rd_data_reg;
    logic                              rd_valid_reg;
    logic                              rd_one_reg;
    logic                              rd_neg_reg;

    logic [KW-1:0]                     k;
    logic [CW-1:0]                     n_cur;
    logic                              issue;
    logic                              trk_last;
    logic [SW-1:0]                     rd_pos;
    logic [PW+SW-1:0]                  rd_pos_ext;
    logic [PW+mtww_pkg::POS_W-1:0]     wr_pos_ext;
    logic [AW-1:0]                     rd_addr;
    logic [AW-1:0]                     wr_addr;
    logic                              out_free;
    logic                              start;
    logic                              mem_we;
    logic signed [AC-1:0]              sample;
    logic signed [AC-1:0]              clamped;

    // Effective window length
    assign k = (32'(cfg.window_len) > MAX_WINDOW) ? KW'(MAX_WINDOW) : KW'(cfg.window_len);

    // Reads per enabled track: the window for init, both window edges for slide (only the base with a zero window)
    assign n_cur = (kind_reg == mtww_pkg::OP_INIT) ? CW'(k)
                 : ((k != '0) ? CW'(2) : CW'(1));

    assign issue    = (state_reg == S_RUN) && cfg.track_enable[trk_reg] && (n_cur != '0);
    assign trk_last = !issue || (j_reg == CW'(n_cur - CW'(1)));

    // Read position: base plus window step (init), base (first slide read) or base plus k (second slide read)
    always_comb begin
        if (kind_reg == mtww_pkg::OP_INIT) begin
            rd_pos = base_reg + SW'(j_reg);
        end else if (j_reg[0]) begin
            rd_pos = base_reg + SW'(k);
        end else begin
            rd_pos = base_reg;
        end
    end

    assign rd_pos_ext = {PW'(0), rd_pos};
    assign wr_pos_ext = {PW'(0), q_op.pos};
    assign rd_addr    = {trk_reg, rd_pos_ext[PW-1:0]};
    assign wr_addr    = {q_op.trk[TW-1:0], wr_pos_ext[PW-1:0]};

    assign out_free = !m_valid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid && out_free;
    assign start    = q_pop && ((q_op.kind == mtww_pkg::OP_INIT) ||
                                (q_op.kind == mtww_pkg::OP_SLIDE));
    assign mem_we   = q_pop && (q_op.kind == mtww_pkg::OP_LOAD);

    // Sample returned by the memory, with past-length positions as 1.0
    assign sample = rd_one_reg ? mtww_pkg::ACC_ONE : AC'(rd_data_reg);

    // Saturate the finished sum
    always_comb begin
        if (acc_reg > mtww_pkg::ACC_WMAX) begin
            clamped = mtww_pkg::ACC_WMAX;
        end else if (acc_reg < mtww_pkg::ACC_WMIN) begin
            clamped = mtww_pkg::ACC_WMIN;
        end else begin
            clamped = acc_reg;
        end
    end

    // Sequencer over tracks and reads
    always_comb begin
        state_next = state_reg;
        trk_next   = trk_reg;
        j_next     = j_reg;
        unique case (state_reg)
            S_IDLE: begin
                trk_next = '0;
                j_next   = '0;
                if (start) begin
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (trk_last) begin
                    j_next = '0;
                    if (trk_reg == TW'(NT - 1)) begin
                        state_next = S_DRAIN;
                    end else begin
                        trk_next = trk_reg + TW'(1);
                    end
                end else begin
                    j_next = j_reg + CW'(1);
                end
            end
            S_DRAIN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, track lengths, running weight and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            trk_reg      <= '0;
            j_reg        <= '0;
            rd_valid_reg <= 1'b0;
            running_reg  <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < NT; i++) begin
                len_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            trk_reg      <= trk_next;
            j_reg        <= j_next;
            rd_valid_reg <= issue;
            // a new result wins over the handshake that empties the register
            if ((q_pop && !start) || (state_reg == S_DONE)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (mem_we && q_op.last) begin
                len_reg[q_op.trk[TW-1:0]] <= mtww_pkg::LEN_W'(q_op.pos) + mtww_pkg::LEN_W'(1);
            end
            if (state_reg == S_DONE) begin
                running_reg <= mtww_pkg::WGT_W'(clamped);
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (start) begin
            kind_reg <= q_op.kind;
            base_reg <= q_op.base;
        end
        rd_one_reg <= (rd_pos >= SW'(len_reg[trk_reg]));
        rd_neg_reg <= (kind_reg == mtww_pkg::OP_SLIDE) && (j_reg == '0) && (k != '0);
        if (start) begin
            acc_reg <= (q_op.kind == mtww_pkg::OP_INIT) ? '0 : AC'(running_reg);
        end else if (rd_valid_reg) begin
            acc_reg <= rd_neg_reg ? (acc_reg - sample) : (acc_reg + sample);
        end
        if (q_pop && !start) begin
            m_weight_reg <= running_reg;
        end else if (state_reg == S_DONE) begin
            m_weight_reg <= mtww_pkg::WGT_W'(clamped);
        end
    end

    // Track value memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= q_op.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_weight = m_weight_reg;

endmodule

FILE: rtl/multi_track_window_weight.sv
// Window weight over up to four tracks of Q4.12 weights. Items enter on the
// s_ stream (cmd in s_tuser) and every item yields exactly one m_ item with
// the running weight after it. Loads and unused commands are answered without
// a pass over the tracks. Init reads, per enabled track, as many values as the
// effective window length (window_len capped at MAX_WINDOW), none with a zero
// window; slide reads the two window edges per enabled track (one with a zero
// window); disabled tracks are passed over. The track memory has a single read
// port that returns one value per cycle, and the execution unit takes no new
// item while it works or while its result waits on m_tready.
// A two-entry queue ahead of the execution unit takes items while it works;
// s_tready drops only when both entries hold items.
// Reset clears track lengths, the running weight and the configuration
// registers; track values are undefined until loaded.
module multi_track_window_weight #(
    parameter int TRACKS      = mtww_pkg::TRACKS_DEF,
    parameter int TRACK_DEPTH = mtww_pkg::TRACK_DEPTH_DEF,
    parameter int MAX_WINDOW  = mtww_pkg::MAX_WINDOW_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // track[1:0], position[13:2], value[29:14], offset[41:30], delta[53:42]
    input  logic [mtww_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [mtww_pkg::CMD_W-1:0]      s_tuser,
    input  logic                            s_tlast,
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // weight[25:0]
    output logic [mtww_pkg::M_TDATA_W-1:0]  m_tdata,
    // Register writes
    input  logic                            cfg_wr_en,
    input  logic [mtww_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mtww_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    mtww_pkg::cfg_t             cfg_reg;
    mtww_pkg::op_t              push_op;
    mtww_pkg::op_t              pop_op;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       q_empty;
    logic [mtww_pkg::WGT_W-1:0] weight;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mtww_pkg::REG_WINDOW_LEN: begin
                    cfg_reg.window_len <= cfg_wdata;
                end
                mtww_pkg::REG_TRACK_ENABLE: begin
                    cfg_reg.track_enable <= cfg_wdata[mtww_pkg::EN_W-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    mtww_front #(
        .TRACKS      (TRACKS),
        .TRACK_DEPTH (TRACK_DEPTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    mtww_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (pop_op),
        .empty   (q_empty)
    );

    mtww_back #(
        .TRACKS      (TRACKS),
        .TRACK_DEPTH (TRACK_DEPTH),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (!q_empty),
        .q_op     (pop_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_weight (weight)
    );

    assign m_tdata = mtww_pkg::M_TDATA_W'(weight);

endmodule

FILE: rtl/mtww_checker.sv
module mtww_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mtww_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;

    // Items taken in but not yet answered
    always_comb begin
        pending_next = pending_reg;
        if ((s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            pending_next = pending_reg + 8'd1;
        end else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready)) begin
            pending_next = pending_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result without an item behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 8'd0)
        else $error("result without a pending item");

    // Reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Weight pads stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[mtww_pkg::M_TDATA_W-1:mtww_pkg::WGT_W] == '0)
        else $error("nonzero pad bits in result");

endmodule

bind multi_track_window_weight mtww_checker u_mtww_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
